// File: rtl/core/tdsc_pkg.sv
// Shared types and constants for the median-filtered TDS converter.
// Used by every module in rtl/core; depends on nothing.
package tdsc_pkg;

   localparam int SAMPLE_W = 12;
   localparam int TEMP_W   = 14;
   localparam int CFG_W    = 13;
   localparam int TDS_W    = 20;
   localparam int DVD_W    = 48;
   localparam int DSR_W    = 24;
   localparam int ACC_W    = 45;

   localparam logic [CFG_W-1:0] REF_MV_RESET     = 13'd3300;
   localparam logic [CFG_W-1:0] FULL_SCALE_RESET = 13'd4096;
   localparam logic [TDS_W-1:0] TDS_MAX          = 20'hFFFFF;

   localparam logic CSR_REF_MV     = 1'b0;
   localparam logic CSR_FULL_SCALE = 1'b1;

   localparam logic KIND_SAMPLE  = 1'b0;
   localparam logic KIND_COMPUTE = 1'b1;

   typedef enum logic {
      MED_IDLE,
      MED_SCAN
   } med_state_type;

   typedef enum logic [3:0] {
      CV_IDLE,
      CV_VGO,
      CV_VWAIT,
      CV_XGO,
      CV_XWAIT,
      CV_SQUARE,
      CV_CUBE,
      CV_LIN,
      CV_ADD3,
      CV_SUB2,
      CV_QGO,
      CV_QWAIT,
      CV_DONE
   } conv_state_type;

   typedef struct packed {
      logic                done;
      logic [SAMPLE_W-1:0] value;
   } med_result_type;

   typedef struct packed {
      logic             valid;
      logic [TDS_W-1:0] tds;
      logic             saturated;
   } conv_result_type;

endpackage

// File: rtl/core/tdsc_ring.sv
// Sample ring storage: one write port, one registered read port.
// Entries never written read as zero through per-entry valid bits; uses tdsc_pkg.
module tdsc_ring #(
   parameter int DEPTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [tdsc_pkg::SAMPLE_W-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [tdsc_pkg::SAMPLE_W-1:0] rd_data
);

   logic [tdsc_pkg::SAMPLE_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]              vld_ff;
   logic [tdsc_pkg::SAMPLE_W-1:0] rd_data_ff;
   logic                          rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

// File: rtl/core/tdsc_median.sv
// Median of the sample ring by bitwise radix selection, one bit per pass over the ring.
// Tracks the two middle ranks at once; depends on tdsc_pkg and reads tdsc_ring.
module tdsc_median #(
   parameter int DEPTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic [$clog2(DEPTH)-1:0]       rd_addr,
   input  logic [tdsc_pkg::SAMPLE_W-1:0]  rd_data,
   output tdsc_pkg::med_result_type       result
);

   localparam int AW = $clog2(DEPTH);
   localparam int IW = $clog2(DEPTH + 1);
   localparam logic [IW-1:0] RANK_LO = IW'((DEPTH - 1) / 2);
   localparam logic [IW-1:0] RANK_HI = IW'(DEPTH / 2);
   localparam logic [IW-1:0] IDX_END = IW'(DEPTH);

   tdsc_pkg::med_state_type state_ff, state_in;

   logic [3:0]                    bit_ff;
   logic [IW-1:0]                 idx_ff;
   logic [tdsc_pkg::SAMPLE_W-1:0] p0_ff, p1_ff;
   logic [IW-1:0]                 r0_ff, r1_ff, c0_ff, c1_ff;
   logic                          done_ff;
   logic [tdsc_pkg::SAMPLE_W-1:0] value_ff;

   logic                          scanning, pass_end;
   logic [tdsc_pkg::SAMPLE_W-1:0] mask, bit_one;
   logic                          hit0, hit1;
   logic [IW-1:0]                 c0_next, c1_next;
   logic [tdsc_pkg::SAMPLE_W-1:0] p0_next, p1_next;
   logic [IW-1:0]                 r0_next, r1_next;
   logic [tdsc_pkg::SAMPLE_W:0]   pair_sum;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tdsc_pkg::MED_IDLE: begin
            if (start) state_in = tdsc_pkg::MED_SCAN;
         end
         tdsc_pkg::MED_SCAN: begin
            if (idx_ff == IDX_END && bit_ff == 4'd0) state_in = tdsc_pkg::MED_IDLE;
         end
         default: state_in = tdsc_pkg::MED_IDLE;
      endcase
   end

   always_comb begin
      scanning = 1'b0;
      case (state_ff)
         tdsc_pkg::MED_SCAN: scanning = 1'b1;
         default:            scanning = 1'b0;
      endcase
      rd_addr  = idx_ff[AW-1:0];
      pass_end = scanning && (idx_ff == IDX_END);
   end

   always_comb begin
      mask     = 12'hFFF << (5'(bit_ff) + 5'd1);
      bit_one  = 12'd1 << bit_ff;
      hit0     = (idx_ff != '0) && (((rd_data ^ p0_ff) & mask) == '0) && !rd_data[bit_ff];
      hit1     = (idx_ff != '0) && (((rd_data ^ p1_ff) & mask) == '0) && !rd_data[bit_ff];
      c0_next  = c0_ff + IW'(hit0);
      c1_next  = c1_ff + IW'(hit1);
      p0_next  = (r0_ff < c0_next) ? p0_ff : (p0_ff | bit_one);
      r0_next  = (r0_ff < c0_next) ? r0_ff : (r0_ff - c0_next);
      p1_next  = (r1_ff < c1_next) ? p1_ff : (p1_ff | bit_one);
      r1_next  = (r1_ff < c1_next) ? r1_ff : (r1_ff - c1_next);
      pair_sum = {1'b0, p0_next} + {1'b0, p1_next};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tdsc_pkg::MED_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= pass_end && (bit_ff == 4'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (start && !scanning) begin
         bit_ff <= 4'd11;
         idx_ff <= '0;
         p0_ff  <= '0;
         p1_ff  <= '0;
         r0_ff  <= RANK_LO;
         r1_ff  <= RANK_HI;
         c0_ff  <= '0;
         c1_ff  <= '0;
      end else if (scanning) begin
         if (pass_end) begin
            p0_ff  <= p0_next;
            p1_ff  <= p1_next;
            r0_ff  <= r0_next;
            r1_ff  <= r1_next;
            c0_ff  <= '0;
            c1_ff  <= '0;
            idx_ff <= '0;
            bit_ff <= bit_ff - 4'd1;
            value_ff <= pair_sum[tdsc_pkg::SAMPLE_W:1];
         end else begin
            c0_ff  <= c0_next;
            c1_ff  <= c1_next;
            idx_ff <= idx_ff + IW'(1);
         end
      end
   end

   assign result.done  = done_ff;
   assign result.value = value_ff;

endmodule

// File: rtl/core/tdsc_div.sv
// Restoring divider, one quotient bit per cycle, shared by the two divisions of the conversion.
// Depends on tdsc_pkg for operand widths.
module tdsc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tdsc_pkg::DVD_W-1:0]  dividend,
   input  logic [tdsc_pkg::DSR_W-1:0]  divisor,
   output logic                        done,
   output logic [tdsc_pkg::DVD_W-1:0]  quotient
);

   localparam logic [5:0] LAST_STEP = 6'(tdsc_pkg::DVD_W - 1);

   logic                        busy_ff, done_ff;
   logic [5:0]                  cnt_ff;
   logic [tdsc_pkg::DVD_W-1:0]  quo_ff;
   logic [tdsc_pkg::DSR_W-1:0]  rem_ff, dsr_ff;
   logic [tdsc_pkg::DSR_W:0]    trial, diff;
   logic                        ge;

   always_comb begin
      trial = {rem_ff, quo_ff[tdsc_pkg::DVD_W-1]};
      diff  = trial - {1'b0, dsr_ff};
      ge    = trial >= {1'b0, dsr_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == LAST_STEP) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= '0;
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 6'd1;
         quo_ff <= {quo_ff[tdsc_pkg::DVD_W-2:0], ge};
         rem_ff <= ge ? diff[tdsc_pkg::DSR_W-1:0] : trial[tdsc_pkg::DSR_W-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/core/tdsc_conv.sv
// Conversion sequencer: median to volts, temperature compensation, cubic polynomial.
// Uses tdsc_div for the two divisions by a variable; depends on tdsc_pkg.
module tdsc_conv (
   input  logic                          clock,
   input  logic                          reset,
   input  tdsc_pkg::med_result_type      median,
   input  logic [tdsc_pkg::TEMP_W-1:0]   temperature,
   input  logic [tdsc_pkg::CFG_W-1:0]    ref_mv,
   input  logic [tdsc_pkg::CFG_W-1:0]    full_scale,
   output tdsc_pkg::conv_result_type     result
);

   // The final divide by 20 is a shift by two and a multiply by ceil(2^26 / 5),
   // exact for the 24-bit operand.
   localparam logic [23:0] RECIP_FIVE = 24'd13421773;

   tdsc_pkg::conv_state_type state_ff, state_in;

   logic [tdsc_pkg::SAMPLE_W-1:0] m_ff;
   logic [31:0]                   v_ff;
   logic [19:0]                   x_ff;
   logic                          big_ff;
   logic [23:0]                   v2_ff;
   logic [27:0]                   v3_ff;
   logic [tdsc_pkg::ACC_W-1:0]    acc_ff;
   logic [47:0]                   prod_ff;
   logic [tdsc_pkg::TDS_W-1:0]    tds_ff;
   logic                          sat_ff;

   logic                          div_start, div_done;
   logic [tdsc_pkg::DVD_W-1:0]    div_dvd, div_quo;
   logic [tdsc_pkg::DSR_W-1:0]    div_dsr;

   logic [tdsc_pkg::CFG_W-1:0]    fs_eff;
   logic [24:0]                   m_ref;
   logic [22:0]                   fs_k;
   logic [44:0]                   v_k;
   logic [14:0]                   temp_k;
   logic [39:0]                   sq;
   logic [43:0]                   cube;
   logic [36:0]                   lin;
   logic [41:0]                   term3;
   logic [38:0]                   term2;
   logic [23:0]                   q_base;
   logic [47:0]                   q_prod;
   logic [21:0]                   q_val;

   always_comb begin
      fs_eff = (full_scale == '0) ? 13'd1 : full_scale;
      m_ref  = 25'(m_ff) * 25'(ref_mv);
      fs_k   = 23'(fs_eff) * 23'd1000;
      v_k    = 45'(v_ff) * 45'd5000;
      temp_k = 15'(temperature) + 15'd2500;
      sq     = 40'(x_ff) * 40'(x_ff);
      cube   = 44'(v2_ff) * 44'(x_ff);
      lin    = 37'(x_ff) * 37'd85739;
      term3  = 42'(v3_ff) * 42'd13342;
      term2  = 39'(v2_ff) * 39'd25586;
      q_base = acc_ff[tdsc_pkg::ACC_W-1] ? '0 : acc_ff[41:18];
      q_prod = 48'(q_base) * 48'(RECIP_FIVE);
      q_val  = prod_ff[47:26];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tdsc_pkg::CV_IDLE:   if (median.done) state_in = tdsc_pkg::CV_VGO;
         tdsc_pkg::CV_VGO:    state_in = tdsc_pkg::CV_VWAIT;
         tdsc_pkg::CV_VWAIT:  if (div_done) state_in = tdsc_pkg::CV_XGO;
         tdsc_pkg::CV_XGO:    state_in = tdsc_pkg::CV_XWAIT;
         tdsc_pkg::CV_XWAIT: begin
            if (div_done) begin
               state_in = (div_quo[tdsc_pkg::DVD_W-1:20] != '0) ? tdsc_pkg::CV_DONE
                                                               : tdsc_pkg::CV_SQUARE;
            end
         end
         tdsc_pkg::CV_SQUARE: state_in = tdsc_pkg::CV_CUBE;
         tdsc_pkg::CV_CUBE:   state_in = tdsc_pkg::CV_LIN;
         tdsc_pkg::CV_LIN:    state_in = tdsc_pkg::CV_ADD3;
         tdsc_pkg::CV_ADD3:   state_in = tdsc_pkg::CV_SUB2;
         tdsc_pkg::CV_SUB2:   state_in = tdsc_pkg::CV_QGO;
         tdsc_pkg::CV_QGO:    state_in = tdsc_pkg::CV_QWAIT;
         tdsc_pkg::CV_QWAIT:  state_in = tdsc_pkg::CV_DONE;
         tdsc_pkg::CV_DONE:   state_in = tdsc_pkg::CV_IDLE;
         default:             state_in = tdsc_pkg::CV_IDLE;
      endcase
   end

   always_comb begin
      div_start    = 1'b0;
      div_dvd      = '0;
      div_dsr      = 24'd1;
      result.valid = 1'b0;
      case (state_ff)
         tdsc_pkg::CV_VGO: begin
            div_start = 1'b1;
            div_dvd   = 48'({m_ref, 16'd0});
            div_dsr   = 24'(fs_k);
         end
         tdsc_pkg::CV_XGO: begin
            div_start = 1'b1;
            div_dvd   = 48'(v_k);
            div_dsr   = 24'(temp_k);
         end
         tdsc_pkg::CV_DONE: result.valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tdsc_pkg::CV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         tdsc_pkg::CV_IDLE:   m_ff <= median.value;
         tdsc_pkg::CV_VWAIT:  v_ff <= div_quo[31:0];
         tdsc_pkg::CV_XWAIT: begin
            x_ff   <= div_quo[19:0];
            big_ff <= div_quo[tdsc_pkg::DVD_W-1:20] != '0;
         end
         tdsc_pkg::CV_SQUARE: v2_ff  <= sq[39:16];
         tdsc_pkg::CV_CUBE:   v3_ff  <= cube[43:16];
         tdsc_pkg::CV_LIN:    acc_ff <= 45'(lin);
         tdsc_pkg::CV_ADD3:   acc_ff <= acc_ff + 45'(term3);
         tdsc_pkg::CV_SUB2:   acc_ff <= acc_ff - 45'(term2);
         tdsc_pkg::CV_QGO:    prod_ff <= q_prod;
         tdsc_pkg::CV_QWAIT: begin
            if (q_val >= {2'b00, tdsc_pkg::TDS_MAX}) begin
               tds_ff <= tdsc_pkg::TDS_MAX;
               sat_ff <= 1'b1;
            end else begin
               tds_ff <= q_val[tdsc_pkg::TDS_W-1:0];
               sat_ff <= 1'b0;
            end
         end
         default: ;
      endcase
   end

   tdsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign result.tds       = big_ff ? tdsc_pkg::TDS_MAX : tds_ff;
   assign result.saturated = big_ff ? 1'b1 : sat_ff;

endmodule

// File: rtl/core/median_tds_conductivity_converter_core.sv
// Top level of the median-filtered TDS converter.
// Instantiates tdsc_ring, tdsc_median and tdsc_conv; depends on tdsc_pkg.
//
// Requests arrive on the req_ stream: req_tuser is the kind (0 stores an ADC
// sample in the next ring slot, 1 computes a new TDS value from the ring
// median and the temperature). Every request returns one response on the
// rsp_ stream with the held TDS value in 0.1 ppm and its saturation flag.
// A sample request answers in the cycle after acceptance. A compute request
// runs the median, one ring read per cycle over twelve bit passes, then two
// 48-step serial divisions, the polynomial and a reciprocal multiply for the
// final scaling. One request is in flight at a time. A finished response waits
// in an output register while rsp_tready is low, and no new request is taken
// until it leaves or leaves in the same cycle. Reset empties the ring (all
// entries read as zero), clears the held result and loads the register
// defaults of 3300 mV and a full scale of 4096. Registers are written through
// csr_; the user writes them only while no request is in flight, which the
// block does not enforce.
module median_tds_conductivity_converter_core #(
   parameter int SAMPLE_COUNT = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // adc_sample [11:0], temperature_centi [25:12]
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // tds_tenths_ppm [19:0]
   output logic        rsp_tuser,   // saturated
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [12:0] csr_wdata
);

   localparam int AW = $clog2(SAMPLE_COUNT);
   localparam logic [AW-1:0] SLOT_LAST = AW'(SAMPLE_COUNT - 1);

   logic [tdsc_pkg::CFG_W-1:0]  ref_mv_ff, full_scale_ff;
   logic [AW-1:0]               slot_ff;
   logic                        busy_ff;
   logic [tdsc_pkg::TEMP_W-1:0] temp_ff;
   logic [tdsc_pkg::TDS_W-1:0]  held_tds_ff;
   logic                        held_sat_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tdsc_pkg::TDS_W-1:0]  rsp_tds_ff;
   logic                        rsp_sat_ff;

   logic                          accept, store, compute;
   logic [AW-1:0]                 rd_addr;
   logic [tdsc_pkg::SAMPLE_W-1:0] rd_data;
   tdsc_pkg::med_result_type      med_res;
   tdsc_pkg::conv_result_type     conv_res;

   assign req_tready = !busy_ff && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign store      = accept && (req_tuser == tdsc_pkg::KIND_SAMPLE);
   assign compute    = accept && (req_tuser == tdsc_pkg::KIND_COMPUTE);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (store || conv_res.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_mv_ff     <= tdsc_pkg::REF_MV_RESET;
         full_scale_ff <= tdsc_pkg::FULL_SCALE_RESET;
         slot_ff       <= '0;
         busy_ff       <= 1'b0;
         held_tds_ff   <= '0;
         held_sat_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               tdsc_pkg::CSR_REF_MV:     ref_mv_ff     <= csr_wdata;
               tdsc_pkg::CSR_FULL_SCALE: full_scale_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (store) begin
            slot_ff <= (slot_ff == SLOT_LAST) ? '0 : slot_ff + AW'(1);
         end
         if (compute) begin
            busy_ff <= 1'b1;
         end else if (conv_res.valid) begin
            busy_ff <= 1'b0;
         end
         if (conv_res.valid) begin
            held_tds_ff <= conv_res.tds;
            held_sat_ff <= conv_res.saturated;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (compute) begin
         temp_ff <= req_tdata[25:12];
      end
      if (conv_res.valid) begin
         rsp_tds_ff <= conv_res.tds;
         rsp_sat_ff <= conv_res.saturated;
      end else if (store) begin
         rsp_tds_ff <= held_tds_ff;
         rsp_sat_ff <= held_sat_ff;
      end
   end

   tdsc_ring #(.DEPTH(SAMPLE_COUNT)) u_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (store),
      .wr_addr (slot_ff),
      .wr_data (req_tdata[11:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tdsc_median #(.DEPTH(SAMPLE_COUNT)) u_median (
      .clock   (clock),
      .reset   (reset),
      .start   (compute),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .result  (med_res)
   );

   tdsc_conv u_conv (
      .clock       (clock),
      .reset       (reset),
      .median      (med_res),
      .temperature (temp_ff),
      .ref_mv      (ref_mv_ff),
      .full_scale  (full_scale_ff),
      .result      (conv_res)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_tds_ff};
   assign rsp_tuser  = rsp_sat_ff;

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for median_tds_conductivity_converter_core.
// Drives sample and compute requests, predicts the held TDS result in the bench itself,
// and checks every response; depends on tdsc_pkg and the core RTL.
`timescale 1ns / 100ps

module testbench;

   typedef struct packed {
      logic                          kind;
      logic [tdsc_pkg::SAMPLE_W-1:0] sample;
      logic [tdsc_pkg::TEMP_W-1:0]   temp;
   } request_type;

   typedef struct packed {
      logic [tdsc_pkg::TDS_W-1:0] tds;
      logic                       sat;
   } tds_reading_type;

   localparam int RING_DEPTH = 32;
   localparam int STALL_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [12:0] csr_wdata = '0;

   request_type     pending_requests[$];
   tds_reading_type expected_readings[$];
   int              tx_idle_pct = 0;
   int              rx_idle_pct = 0;
   int              hold_request = 0;
   int              hold_count = 0;
   int              error_count = 0;
   int              request_count = 0;
   int              compute_count = 0;
   int              saturated_count = 0;
   int              quiet_cycles = 0;

   logic [tdsc_pkg::SAMPLE_W-1:0] model_ring[RING_DEPTH];
   int                            model_slot = 0;
   logic [tdsc_pkg::TDS_W-1:0]    model_tds = '0;
   logic                          model_sat = 1'b0;
   logic [tdsc_pkg::CFG_W-1:0]    model_ref_mv = tdsc_pkg::REF_MV_RESET;
   logic [tdsc_pkg::CFG_W-1:0]    model_full_scale = tdsc_pkg::FULL_SCALE_RESET;

   median_tds_conductivity_converter_core dut (.*);

   always #4 clock = ~clock;

   function automatic longint ring_median_value();
      int sorted[RING_DEPTH];
      int key;
      int j;
      for (int i = 0; i < RING_DEPTH; i++) sorted[i] = model_ring[i];
      for (int i = 1; i < RING_DEPTH; i++) begin
         key = sorted[i];
         j = i - 1;
         while (j >= 0 && sorted[j] > key) begin
            sorted[j + 1] = sorted[j];
            j--;
         end
         sorted[j + 1] = key;
      end
      return (sorted[RING_DEPTH / 2] + sorted[RING_DEPTH / 2 - 1]) / 2;
   endfunction

   function automatic void predict_tds(request_type r);
      longint fs, volts, comp, sq, cube, num, tds;
      tds_reading_type reading;
      if (r.kind == tdsc_pkg::KIND_SAMPLE) begin
         model_ring[model_slot] = r.sample;
         model_slot = (model_slot + 1) % RING_DEPTH;
      end else begin
         fs = (model_full_scale == 0) ? 1 : model_full_scale;
         volts = (ring_median_value() * model_ref_mv * 65536) / (fs * 1000);
         comp = (volts * 5000) / (2500 + r.temp);
         if (comp >= (64'd1 << 20)) begin
            model_tds = tdsc_pkg::TDS_MAX;
            model_sat = 1'b1;
         end else begin
            sq = (comp * comp) >>> 16;
            cube = (sq * comp) >>> 16;
            num = 13342 * cube - 25586 * sq + 85739 * comp;
            if (num < 0) num = 0;
            tds = num / (20 * 65536);
            if (tds >= tdsc_pkg::TDS_MAX) begin
               model_tds = tdsc_pkg::TDS_MAX;
               model_sat = 1'b1;
            end else begin
               model_tds = tds[tdsc_pkg::TDS_W-1:0];
               model_sat = 1'b0;
            end
         end
      end
      reading.tds = model_tds;
      reading.sat = model_sat;
      expected_readings.push_back(reading);
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Driver: takes requests from the pending queue and predicts each one on acceptance.
   always @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         predict_tds(request_type'({req_tuser, req_tdata[11:0], req_tdata[25:12]}));
         request_count++;
         if (req_tuser == tdsc_pkg::KIND_COMPUTE) compute_count++;
      end
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_requests.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tuser <= pending_requests[0].kind;
            req_tdata <= {6'b0, pending_requests[0].temp, pending_requests[0].sample};
            void'(pending_requests.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver with an optional long hold-off.
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_count <= hold_request;
         hold_request = 0;
         rsp_tready <= 1'b0;
      end else if (hold_count > 0) begin
         hold_count <= hold_count - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset && ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Monitor.
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         if (expected_readings.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata[19:0], 0);
         end else begin
            if (rsp_tdata[19:0] !== expected_readings[0].tds)
               report_mismatch("tds", rsp_tdata[19:0], expected_readings[0].tds);
            if (rsp_tuser !== expected_readings[0].sat)
               report_mismatch("saturated", rsp_tuser, expected_readings[0].sat);
            if (rsp_tuser) saturated_count++;
            void'(expected_readings.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_csr(logic index, logic [12:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      if (index == tdsc_pkg::CSR_REF_MV) model_ref_mv = value;
      else model_full_scale = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_requests.size() > 0 || expected_readings.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic add_request(logic kind, int sample, int temp);
      request_type r;
      r.kind = kind;
      r.sample = sample;
      r.temp = temp;
      pending_requests.push_back(r);
   endtask

   task automatic add_random_requests(int count, int sample_max);
      int temp;
      for (int i = 0; i < count; i++) begin
         temp = ($urandom_range(9) == 0) ? $urandom_range(16383) : $urandom_range(10000);
         if ($urandom_range(9) == 0)
            add_request(tdsc_pkg::KIND_COMPUTE, $urandom_range(4095), temp);
         else
            add_request(tdsc_pkg::KIND_SAMPLE, $urandom_range(sample_max),
                        $urandom_range(16383));
      end
   endtask

   initial begin
      for (int i = 0; i < RING_DEPTH; i++) model_ring[i] = '0;
      tx_idle_pct = 26;
      rx_idle_pct = 82;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty ring, field extremes and ignored fields.
      add_request(tdsc_pkg::KIND_COMPUTE, 4095, 0);
      add_request(tdsc_pkg::KIND_SAMPLE, 4095, 16383);
      add_request(tdsc_pkg::KIND_COMPUTE, 0, 16383);
      for (int i = 0; i < 16; i++) add_request(tdsc_pkg::KIND_SAMPLE, 4095, 0);
      add_request(tdsc_pkg::KIND_COMPUTE, 4095, 0);
      add_request(tdsc_pkg::KIND_COMPUTE, 0, 10000);
      add_request(tdsc_pkg::KIND_SAMPLE, 1, 5000);
      add_request(tdsc_pkg::KIND_COMPUTE, 2730, 2500);
      add_request(tdsc_pkg::KIND_SAMPLE, 0, 0);
      wait_drained();

      write_csr(tdsc_pkg::CSR_REF_MV, 13'd5000);
      write_csr(tdsc_pkg::CSR_FULL_SCALE, 13'd1);
      add_random_requests(250, 4095);
      wait_drained();

      write_csr(tdsc_pkg::CSR_REF_MV, 13'd1000);
      write_csr(tdsc_pkg::CSR_FULL_SCALE, 13'd4096);
      tx_idle_pct = 82;
      rx_idle_pct = 26;
      add_random_requests(300, 63);
      wait_drained();

      write_csr(tdsc_pkg::CSR_REF_MV, 13'd8191);
      write_csr(tdsc_pkg::CSR_FULL_SCALE, 13'd0);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      add_random_requests(300, 4095);
      hold_request = 1500;
      wait_drained();

      write_csr(tdsc_pkg::CSR_REF_MV, 13'd3300);
      write_csr(tdsc_pkg::CSR_FULL_SCALE, 13'd8191);
      add_random_requests(300, 4095);
      wait_drained();

      write_csr(tdsc_pkg::CSR_REF_MV, 13'd0);
      write_csr(tdsc_pkg::CSR_FULL_SCALE, 13'd4096);
      add_random_requests(150, 4095);
      wait_drained();

      $display("Covered %0d requests (%0d computes, %0d saturated responses) over six",
               request_count, compute_count, saturated_count);
      $display("register settings with sender and receiver idling and a long receiver hold.");
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/tdsc_pkg.sv
rtl/core/tdsc_ring.sv
rtl/core/tdsc_median.sv
rtl/core/tdsc_div.sv
rtl/core/tdsc_conv.sv
rtl/core/median_tds_conductivity_converter_core.sv
tb/sv/testbench.sv
